[design/lrts_pkg.sv]
// Shared types and constants for the least-run task scheduler.
// Used by lrts_table and least_run_task_scheduler; no dependencies.
`timescale 1ns / 1ps
package lrts_pkg;
    localparam int TaskSlotsDefault = 16;

    typedef enum logic [2:0] {
        ST_UNUSED   = 3'd0,
        ST_READY    = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_BLOCKED  = 3'd3,
        ST_SLEEPING = 3'd4,
        ST_EXITED   = 3'd5
    } task_st_t;

    localparam logic [2:0] FN_SCHED = 3'd0;
    localparam logic [2:0] FN_SLEEP = 3'd1;
    localparam logic [2:0] FN_SPAWN = 3'd2;
    localparam logic [2:0] FN_KILL  = 3'd3;
    localparam logic [2:0] FN_EXIT  = 3'd4;
    localparam logic [2:0] FN_WAIT  = 3'd5;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_NO_SLOT = 2'd1;
    localparam logic [1:0] ERR_NO_PID  = 2'd2;
    localparam logic [1:0] ERR_NO_RDY  = 2'd3;

    // One table entry as held in memory.
    typedef struct packed {
        logic [2:0]  st;
        logic [15:0] pid;
        logic [31:0] cnt;
        logic [31:0] wake;
        logic [5:0]  waits;
    } entry_t;

    localparam logic [15:0] PID_FIRST = 16'd2;
endpackage

[design/lrts_table.sv]
// Task table memory: one synchronous read port, one write port.
// Depends on lrts_pkg for the entry type.
`timescale 1ns / 1ps
module lrts_table #(
    parameter int TASK_SLOTS = lrts_pkg::TaskSlotsDefault,
    localparam int AW = $clog2(TASK_SLOTS)
) (
    input  logic                  aclk,
    input  logic [AW-1:0]         rd_addr,
    output lrts_pkg::entry_t      rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  lrts_pkg::entry_t      wr_data
);
    lrts_pkg::entry_t mem [TASK_SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

[design/least_run_task_scheduler.sv]
// Least-run task scheduler top level: sequencer around the task table.
// Depends on lrts_pkg and lrts_table.
//
//  channel | dir | fields (tdata low bit up)
//  s_axis  | in  | func[2:0] now[34:3] sleep_ticks[66:35] target_pid[82:67]
//  m_axis  | out | running_slot[3:0] running_pid[19:4] spawned_pid[35:20]
//          |     | error_code[37:36]
//
// Reset runs a clearing pass over all TASK_SLOTS entries, no word accepted meanwhile.
// The table has one read and one write port; pid search, waiter release,
// wake-up and minimum search each sweep all TASK_SLOTS entries. The result
// register holds a word while m_axis_tready is low; the next word is taken
// once the result is gone.
`timescale 1ns / 1ps
module least_run_task_scheduler #(
    parameter int TASK_SLOTS = lrts_pkg::TaskSlotsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // func, now, sleep_ticks, target_pid
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // running_slot, running_pid, spawned_pid, error_code
);
    localparam int AW = $clog2(TASK_SLOTS);
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam logic [CW-1:0] LAST = CW'(TASK_SLOTS - 1);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_FIND  = 12'b000000000100, // search free slot or pid
        S_REL   = 12'b000000001000, // release waiters of victim
        S_PREC  = 12'b000000010000, // read current entry
        S_CUR   = 12'b000000100000, // modify current entry
        S_WAKE  = 12'b000001000000, // wake sleepers, current entry back to ready
        S_MIN   = 12'b000010000000, // minimum search
        S_PICKR = 12'b000100000000,
        S_PICK  = 12'b001000000000,
        S_SPAWN = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } fsm_t;

    fsm_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;       // address issued
    logic          rv_reg, rv_next;         // read data valid this cycle
    logic [AW-1:0] ra_reg, ra_next;         // address of data now on rd_data
    logic [2:0]    func_reg, func_next;
    logic [31:0]   now_reg, now_next, tick_reg, tick_next;
    logic [15:0]   tpid_reg, tpid_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [15:0]   npid_reg, npid_next;
    logic          found_reg, found_next;
    logic [AW-1:0] hit_reg, hit_next;
    logic          best_v_reg, best_v_next;
    logic [AW-1:0] best_reg, best_next;
    logic [31:0]   bcnt_reg, bcnt_next;
    logic [1:0]    err_reg, err_next;
    logic [15:0]   spid_reg, spid_next;
    logic [15:0]   rpid_reg, rpid_next;
    logic          ov_reg, ov_next;

    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    lrts_pkg::entry_t rd_data, wr_data, e;

    lrts_table #(.TASK_SLOTS(TASK_SLOTS)) u_table (
        .aclk(aclk), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {2'b00, err_reg, spid_reg, rpid_reg, 4'(cur_reg)};

    always_comb begin
        state_next = state_reg; idx_next = idx_reg; rv_next = 1'b0; ra_next = ra_reg;
        func_next = func_reg; now_next = now_reg; tick_next = tick_reg;
        tpid_next = tpid_reg; cur_next = cur_reg; npid_next = npid_reg;
        found_next = found_reg; hit_next = hit_reg; best_v_next = best_v_reg;
        best_next = best_reg; bcnt_next = bcnt_reg; err_next = err_reg;
        spid_next = spid_reg; rpid_next = rpid_reg; ov_next = ov_reg;
        rd_addr = idx_reg[AW-1:0];
        wr_en = 1'b0; wr_addr = ra_reg; e = rd_data; wr_data = rd_data;
        if (ov_reg && m_axis_tready) ov_next = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                wr_en = 1'b1; wr_addr = idx_reg[AW-1:0];
                wr_data = '0;
                wr_data.st = (idx_reg == '0) ? lrts_pkg::ST_RUNNING : lrts_pkg::ST_UNUSED;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_axis_tvalid && !ov_reg) begin
                    func_next = s_axis_tdata[2:0];
                    now_next  = s_axis_tdata[34:3];
                    tick_next = s_axis_tdata[66:35];
                    tpid_next = s_axis_tdata[82:67];
                    spid_next = '0; err_next = lrts_pkg::ERR_OK;
                    found_next = 1'b0; idx_next = '0; rv_next = 1'b0;
                    case (s_axis_tdata[2:0])
                        lrts_pkg::FN_SCHED, lrts_pkg::FN_SLEEP,
                        lrts_pkg::FN_EXIT: state_next = S_PREC;
                        lrts_pkg::FN_SPAWN, lrts_pkg::FN_KILL,
                        lrts_pkg::FN_WAIT: state_next = S_FIND;
                        default: begin
                            idx_next = CW'(cur_reg); state_next = S_PICKR;
                            best_next = cur_reg;
                        end
                    endcase
                end
            end
            S_FIND: begin
                // sweep: issue idx, examine previous read
                if (rv_reg && !found_reg) begin
                    if (func_reg == lrts_pkg::FN_SPAWN) begin
                        if (e.st == lrts_pkg::ST_UNUSED || e.st == lrts_pkg::ST_EXITED) begin
                            found_next = 1'b1; hit_next = ra_reg;
                        end
                    end else if (e.st != lrts_pkg::ST_UNUSED && e.pid == tpid_reg) begin
                        found_next = 1'b1; hit_next = ra_reg;
                    end
                end
                if (idx_reg <= LAST) begin
                    rv_next = 1'b1; ra_next = idx_reg[AW-1:0]; idx_next = idx_reg + 1'b1;
                end else if (!rv_reg) begin
                    idx_next = '0;
                    if (!found_reg) begin
                        err_next = (func_reg == lrts_pkg::FN_SPAWN) ?
                                   lrts_pkg::ERR_NO_SLOT : lrts_pkg::ERR_NO_PID;
                        best_next = cur_reg; idx_next = CW'(cur_reg); state_next = S_PICKR;
                    end else if (func_reg == lrts_pkg::FN_SPAWN) begin
                        state_next = S_SPAWN;
                    end else if (func_reg == lrts_pkg::FN_KILL) begin
                        state_next = S_REL;
                    end else begin
                        state_next = S_PREC;
                    end
                end
            end
            S_SPAWN: begin
                wr_en = 1'b1; wr_addr = hit_reg;
                wr_data = '0; wr_data.st = lrts_pkg::ST_READY; wr_data.pid = npid_reg;
                spid_next = npid_reg; npid_next = npid_reg + 1'b1;
                best_next = cur_reg; idx_next = CW'(cur_reg); state_next = S_PICKR;
            end
            S_REL: begin
                // release waiters on hit and mark the victim exited, in the same sweep
                if (rv_reg) begin
                    if (ra_reg == hit_reg) begin
                        wr_en = 1'b1; wr_data.st = lrts_pkg::ST_EXITED;
                    end else if (e.st == lrts_pkg::ST_BLOCKED && e.waits[AW-1:0] == hit_reg) begin
                        wr_en = 1'b1; wr_data.st = lrts_pkg::ST_READY;
                    end
                end
                if (idx_reg <= LAST) begin
                    rv_next = 1'b1; ra_next = idx_reg[AW-1:0]; idx_next = idx_reg + 1'b1;
                end else if (!rv_reg) begin
                    idx_next = '0;
                    state_next = (func_reg == lrts_pkg::FN_EXIT) ? S_WAKE : S_PREC;
                end
            end
            S_PREC: begin
                rd_addr = cur_reg; ra_next = cur_reg; state_next = S_CUR;
            end
            S_CUR: begin
                // per-func change of the current entry, plus count reset
                wr_en = 1'b1;
                if (e.st == lrts_pkg::ST_RUNNING) begin
                    case (func_reg)
                        lrts_pkg::FN_SLEEP: begin
                            wr_data.st = lrts_pkg::ST_SLEEPING;
                            wr_data.wake = now_reg + tick_reg;
                        end
                        lrts_pkg::FN_WAIT: begin
                            wr_data.st = lrts_pkg::ST_BLOCKED;
                            wr_data.waits = 6'(hit_reg);
                        end
                        default: ;
                    endcase
                end
                if (e.pid != 16'd0 && e.pid != 16'd1) wr_data.cnt = 32'd1;
                idx_next = '0; rv_next = 1'b0;
                if (func_reg == lrts_pkg::FN_EXIT && e.st == lrts_pkg::ST_RUNNING) begin
                    hit_next = cur_reg; state_next = S_REL;
                end else begin
                    state_next = S_WAKE;
                end
            end
            S_WAKE: begin
                if (rv_reg) begin
                    if (e.st == lrts_pkg::ST_SLEEPING && e.wake <= now_reg) begin
                        wr_en = 1'b1; wr_data.st = lrts_pkg::ST_READY; wr_data.wake = '0;
                    end else if (ra_reg == cur_reg && e.st == lrts_pkg::ST_RUNNING) begin
                        wr_en = 1'b1; wr_data.st = lrts_pkg::ST_READY;
                    end
                end
                if (idx_reg <= LAST) begin
                    rv_next = 1'b1; ra_next = idx_reg[AW-1:0]; idx_next = idx_reg + 1'b1;
                end else if (!rv_reg) begin
                    idx_next = '0; best_v_next = 1'b0; state_next = S_MIN;
                end
            end
            S_MIN: begin
                if (rv_reg && e.st == lrts_pkg::ST_READY &&
                    (!best_v_reg || e.cnt < bcnt_reg)) begin
                    best_v_next = 1'b1; best_next = ra_reg; bcnt_next = e.cnt;
                end
                if (idx_reg <= LAST) begin
                    rv_next = 1'b1; ra_next = idx_reg[AW-1:0]; idx_next = idx_reg + 1'b1;
                end else if (!rv_reg) begin
                    if (!best_v_reg) begin
                        err_next = lrts_pkg::ERR_NO_RDY; best_next = cur_reg;
                    end
                    idx_next = best_v_reg ? CW'(best_reg) : CW'(cur_reg);
                    state_next = S_PICKR;
                end
            end
            S_PICKR: begin
                rd_addr = best_reg; ra_next = best_reg; state_next = S_PICK;
            end
            S_PICK: begin
                // run the pick, when the minimum search found one and no error is set
                if (err_reg == lrts_pkg::ERR_OK && (state_reg == S_PICK) &&
                    best_v_reg && (func_reg != lrts_pkg::FN_SPAWN) &&
                    (func_reg <= lrts_pkg::FN_WAIT)) begin
                    wr_en = 1'b1; wr_data.st = lrts_pkg::ST_RUNNING;
                    wr_data.cnt = e.cnt + 32'd1;
                    cur_next = best_reg;
                end
                rpid_next = e.pid;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!ov_reg) begin
                    ov_next = 1'b1; best_v_next = 1'b0; state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR; idx_reg <= '0; rv_reg <= 1'b0; cur_reg <= '0;
            npid_reg <= lrts_pkg::PID_FIRST; ov_reg <= 1'b0; best_v_reg <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next; idx_reg <= idx_next; rv_reg <= rv_next;
            cur_reg <= cur_next; npid_reg <= npid_next; ov_reg <= ov_next;
            best_v_reg <= best_v_next; found_reg <= found_next;
        end
        ra_reg <= ra_next; func_reg <= func_next; now_reg <= now_next;
        tick_reg <= tick_next; tpid_reg <= tpid_next; hit_reg <= hit_next;
        best_reg <= best_next; bcnt_reg <= bcnt_next; err_reg <= err_next;
        spid_reg <= spid_next; rpid_reg <= rpid_next;
    end
endmodule

[bench/least_run_task_scheduler_checker.sv]
// Checker for the least-run task scheduler: watches both stream channels,
// predicts each result word from its own task table and compares. Uses lrts_pkg.
`timescale 1ns / 1ps
module least_run_task_scheduler_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    output int          fail_count,
    output int          pending
);
    localparam int NSLOT = 16;

    typedef struct packed {
        logic [3:0]  slot;
        logic [15:0] pid;
        logic [15:0] spawned;
        logic [1:0]  err;
    } sched_result_t;

    lrts_pkg::task_st_t tbl_st [NSLOT];
    logic [15:0] tbl_pid  [NSLOT];
    logic [31:0] tbl_cnt  [NSLOT];
    logic [31:0] tbl_wake [NSLOT];
    logic [3:0]  tbl_waits[NSLOT];
    logic [3:0]  cur;
    logic [15:0] pid_next;

    sched_result_t expected_results[$];

    function automatic int lookup_pid(logic [15:0] pid);
        for (int i = 0; i < NSLOT; i++)
            if (tbl_st[i] != lrts_pkg::ST_UNUSED && tbl_pid[i] == pid) return i;
        return -1;
    endfunction

    function automatic void wake_waiters(int slot);
        for (int i = 0; i < NSLOT; i++)
            if (tbl_st[i] == lrts_pkg::ST_BLOCKED && tbl_waits[i] == slot[3:0])
                tbl_st[i] = lrts_pkg::ST_READY;
    endfunction

    function automatic logic [1:0] pick_next(logic [31:0] now);
        int best;
        best = -1;
        if (tbl_pid[cur] != 16'd0 && tbl_pid[cur] != 16'd1) tbl_cnt[cur] = 32'd1;
        for (int i = 0; i < NSLOT; i++)
            if (tbl_st[i] == lrts_pkg::ST_SLEEPING && tbl_wake[i] <= now) begin
                tbl_st[i] = lrts_pkg::ST_READY;
                tbl_wake[i] = '0;
            end
        if (tbl_st[cur] == lrts_pkg::ST_RUNNING) tbl_st[cur] = lrts_pkg::ST_READY;
        for (int i = 0; i < NSLOT; i++)
            if (tbl_st[i] == lrts_pkg::ST_READY &&
                (best < 0 || tbl_cnt[i] < tbl_cnt[best])) best = i;
        if (best < 0) return lrts_pkg::ERR_NO_RDY;
        cur = best[3:0];
        tbl_st[best] = lrts_pkg::ST_RUNNING;
        tbl_cnt[best] = tbl_cnt[best] + 32'd1;
        return lrts_pkg::ERR_OK;
    endfunction

    function automatic sched_result_t apply_request(logic [87:0] d);
        logic [2:0]    fn;
        logic [31:0]   now, ticks;
        logic [15:0]   tpid;
        logic          cur_run;
        int            s;
        sched_result_t r;
        fn = d[2:0];
        now = d[34:3];
        ticks = d[66:35];
        tpid = d[82:67];
        cur_run = (tbl_st[cur] == lrts_pkg::ST_RUNNING);
        r = '0;
        case (fn)
            lrts_pkg::FN_SCHED: r.err = pick_next(now);
            lrts_pkg::FN_SLEEP: begin
                if (cur_run) begin
                    tbl_st[cur] = lrts_pkg::ST_SLEEPING;
                    tbl_wake[cur] = now + ticks;
                end
                r.err = pick_next(now);
            end
            lrts_pkg::FN_SPAWN: begin
                s = -1;
                for (int i = NSLOT - 1; i >= 0; i--)
                    if (tbl_st[i] == lrts_pkg::ST_UNUSED || tbl_st[i] == lrts_pkg::ST_EXITED)
                        s = i;
                if (s < 0) begin
                    r.err = lrts_pkg::ERR_NO_SLOT;
                end else begin
                    tbl_st[s] = lrts_pkg::ST_READY;
                    tbl_cnt[s] = '0;
                    tbl_wake[s] = '0;
                    tbl_waits[s] = '0;
                    tbl_pid[s] = pid_next;
                    r.spawned = pid_next;
                    pid_next = pid_next + 16'd1;
                end
            end
            lrts_pkg::FN_KILL: begin
                s = lookup_pid(tpid);
                if (s < 0) begin
                    r.err = lrts_pkg::ERR_NO_PID;
                end else begin
                    wake_waiters(s);
                    tbl_st[s] = lrts_pkg::ST_EXITED;
                    r.err = pick_next(now);
                end
            end
            lrts_pkg::FN_EXIT: begin
                if (cur_run) begin
                    wake_waiters(int'(cur));
                    tbl_st[cur] = lrts_pkg::ST_EXITED;
                end
                r.err = pick_next(now);
            end
            lrts_pkg::FN_WAIT: begin
                s = lookup_pid(tpid);
                if (s < 0) begin
                    r.err = lrts_pkg::ERR_NO_PID;
                end else begin
                    if (cur_run) begin
                        tbl_st[cur] = lrts_pkg::ST_BLOCKED;
                        tbl_waits[cur] = s[3:0];
                    end
                    r.err = pick_next(now);
                end
            end
            default: ;
        endcase
        r.slot = cur;
        r.pid = tbl_pid[cur];
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        sched_result_t got, exp_r;
        if (!aresetn) begin
            for (int i = 0; i < NSLOT; i++) begin
                tbl_st[i] = lrts_pkg::ST_UNUSED;
                tbl_pid[i] = '0;
                tbl_cnt[i] = '0;
                tbl_wake[i] = '0;
                tbl_waits[i] = '0;
            end
            tbl_st[0] = lrts_pkg::ST_RUNNING;
            cur = '0;
            pid_next = lrts_pkg::PID_FIRST;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_request(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[3:0], m_axis_tdata[19:4], m_axis_tdata[35:20],
                       m_axis_tdata[37:36]};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch exp slot %0d pid %0d spawned %0d err %0d",
                                 $time, exp_r.slot, exp_r.pid, exp_r.spawned, exp_r.err);
                        $display("%0t:          got slot %0d pid %0d spawned %0d err %0d",
                                 $time, got.slot, got.pid, got.spawned, got.err);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

[bench/least_run_task_scheduler_tb.sv]
// Testbench top for least_run_task_scheduler: drives request words with random
// idling and gives the verdict. Depends on lrts_pkg and the checker module.
`timescale 1ns / 1ps
module least_run_task_scheduler_tb;
    localparam int RANDOM_ITEMS = 1600;
    localparam int STALL_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          quiet_phase;
    logic [31:0] clock_now;

    least_run_task_scheduler u_top (.*);

    least_run_task_scheduler_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog: cycles with no accepted word
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("least_run_task_scheduler test failed");
            $finish;
        end
    end

    // result side stalls in bursts
    initial begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 10);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic send_request(logic [2:0] fn, logic [31:0] now, logic [31:0] ticks,
                                logic [15:0] tpid);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, tpid, ticks, now, fn};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // mostly valid pids near those handed out, sometimes anything
    function automatic logic [15:0] pick_pid();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 1));
            default: return 16'($urandom_range(2, 60));
        endcase
    endfunction

    initial begin
        logic [2:0] fn;
        logic [31:0] ticks;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        quiet_phase = 1'b0;
        idle_cycles = 0;
        clock_now = 32'd100;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle table, errors, fill the table, sleep wake, wait, kill, exit
        send_request(lrts_pkg::FN_SCHED, 32'd0, 32'd0, 16'd0);
        send_request(lrts_pkg::FN_KILL, 32'd0, 32'd0, 16'hFFFF);
        send_request(lrts_pkg::FN_WAIT, 32'd0, 32'd0, 16'd7);
        send_request(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(3'd7, 32'd0, 32'd0, 16'd0);
        for (int i = 0; i < 16; i++) send_request(lrts_pkg::FN_SPAWN, 32'd1, 32'd0, 16'd0);
        send_request(lrts_pkg::FN_SCHED, 32'd2, 32'd0, 16'd0);
        send_request(lrts_pkg::FN_SLEEP, 32'hFFFF_FFF0, 32'h20, 16'd0);
        send_request(lrts_pkg::FN_WAIT, 32'd3, 32'd0, 16'd2);
        send_request(lrts_pkg::FN_KILL, 32'd4, 32'd0, 16'd2);
        send_request(lrts_pkg::FN_EXIT, 32'd5, 32'd0, 16'd0);
        send_request(lrts_pkg::FN_SCHED, 32'hFFFF_FFFF, 32'd0, 16'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i > RANDOM_ITEMS - 200) quiet_phase = 1'b1;
            clock_now = clock_now + $urandom_range(0, 50);
            case ($urandom_range(0, 11))
                0, 1, 2: fn = lrts_pkg::FN_SCHED;
                3, 4:    fn = lrts_pkg::FN_SLEEP;
                5, 6:    fn = lrts_pkg::FN_SPAWN;
                7:       fn = lrts_pkg::FN_KILL;
                8:       fn = lrts_pkg::FN_EXIT;
                9, 10:   fn = lrts_pkg::FN_WAIT;
                default: fn = 3'($urandom_range(0, 7));
            endcase
            ticks = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 200);
            send_request(fn, ($urandom_range(0, 31) == 0) ? $urandom : clock_now, ticks,
                         pick_pid());
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("least_run_task_scheduler test passed");
        else
            $display("least_run_task_scheduler test failed");
        $finish;
    end
endmodule

[least_run_task_scheduler.f]
design/lrts_pkg.sv
design/lrts_table.sv
design/least_run_task_scheduler.sv
bench/least_run_task_scheduler_checker.sv
bench/least_run_task_scheduler_tb.sv
